>>> design/tbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, constants and helpers of the tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MAX         = 2'd3;
  localparam ctr_t CTR_ZERO        = 2'd0;
  localparam ctr_t CTR_WEAK_NT     = 2'd1;
  localparam ctr_t CTR_WEAK_GLOBAL = 2'd2;

  // One word of the global-indexed memory: chooser and global counter side by side.
  typedef struct packed {
    ctr_t chooser;
    ctr_t gctr;
  } gword_t;

  typedef struct packed {
    logic predicted_taken;
    logic used_global;
  } result_t;

  function automatic ctr_t sat_move(input ctr_t c, input logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_ZERO) ? CTR_ZERO : c - 2'd1;
    end
    return r;
  endfunction

endpackage

>>> design/tbp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_in_if
// Channel carrying one resolved conditional branch.
// ----------------------------------------------------------------------------
interface tbp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pc;
  logic        taken;

  modport source (output valid, output pc, output taken, input ready);
  modport sink   (input valid, input pc, input taken, output ready);
endinterface

>>> design/tbp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_out_if
// Channel carrying one prediction result.
// ----------------------------------------------------------------------------
interface tbp_out_if;
  logic valid;
  logic ready;
  logic predicted_taken;
  logic used_global;

  modport source (output valid, output predicted_taken, output used_global, input ready);
  modport sink   (input valid, input predicted_taken, input used_global, output ready);
endinterface

>>> design/tournament_branch_predictor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_unit
// Tournament predictor of 2-bit counters: global, local and chooser tables.
// ----------------------------------------------------------------------------
// Usage:
// The branch channel takes one resolved conditional branch (pc, taken) per
// transfer. For each one, the prediction channel gives one result: the
// tournament prediction made before training, and whether the chooser picked
// the global component. All tables are then trained with the outcome.
// Each branch passes the v1 and v2 stages, then its result waits in the
// output buffer. No branch is taken while one is in v1, as the local
// history must be read from its memory before the local counter can be
// read from the next one, and the following branch needs it written back.
// The tables live in three synchronous RAMs. After reset a clearing pass
// over 2^max(GLOBAL_HIST_BITS, LOCAL_HIST_BITS, PC_INDEX_BITS) indices
// (1024 by default) writes reset values; branch.ready stays low meanwhile.
// Results wait in a two-entry output buffer; while the receiver stalls,
// further branches are taken only as long as a buffer slot remains for them.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_unit #(
  parameter int GLOBAL_HIST_BITS = 9,
  parameter int LOCAL_HIST_BITS  = 10,
  parameter int PC_INDEX_BITS    = 10
) (
  input  logic     clk,
  input  logic     rst,
  tbp_in_if.sink   branch,
  tbp_out_if.source prediction
);
  import tbp_pkg::*;

  localparam int GL_MAX   = (GLOBAL_HIST_BITS > LOCAL_HIST_BITS) ?
                            GLOBAL_HIST_BITS : LOCAL_HIST_BITS;
  localparam int CLR_BITS = (GL_MAX > PC_INDEX_BITS) ? GL_MAX : PC_INDEX_BITS;

  // Clearing pass
  logic                clearing;
  logic [CLR_BITS-1:0] clr_idx;

  // Pipeline stages
  logic                        v1;
  logic [PC_INDEX_BITS-1:0]    s1_pidx;
  logic                        s1_taken;
  logic                        v2;
  logic [LOCAL_HIST_BITS-1:0]  s2_lidx;
  logic [GLOBAL_HIST_BITS-1:0] s2_gidx;
  logic                        s2_taken;
  logic [GLOBAL_HIST_BITS-1:0] ghist;

  // Memory ports
  logic [LOCAL_HIST_BITS-1:0]  lh_rdata;
  logic                        lh_we;
  logic [PC_INDEX_BITS-1:0]    lh_waddr;
  logic [LOCAL_HIST_BITS-1:0]  lh_wdata;
  ctr_t                        lc_rdata;
  logic                        lc_we;
  logic [LOCAL_HIST_BITS-1:0]  lc_waddr;
  ctr_t                        lc_wdata;
  gword_t                      g_rdata;
  logic                        g_we;
  logic [GLOBAL_HIST_BITS-1:0] g_waddr;
  gword_t                      g_wdata;

  // Stage arithmetic
  logic [LOCAL_HIST_BITS:0]    lh_wide;
  logic [GLOBAL_HIST_BITS:0]   gh_wide;
  logic                        gp;
  logic                        lp;
  logic                        use_g;
  ctr_t                        gc_new;
  ctr_t                        lc_new;
  ctr_t                        cc_new;
  result_t                     res;

  // Output buffer
  result_t     buf0;
  result_t     buf1;
  result_t     buf0_next;
  result_t     buf1_next;
  logic [1:0]  cnt;
  logic [1:0]  cnt_next;
  logic        push;
  logic        pop;
  logic [2:0]  occupancy;

  tbp_ram #(.WIDTH(LOCAL_HIST_BITS), .DEPTH(2 ** PC_INDEX_BITS)) u_lhist (
    .clk   (clk),
    .we    (lh_we),
    .waddr (lh_waddr),
    .wdata (lh_wdata),
    .raddr (branch.pc[PC_INDEX_BITS-1:0]),
    .rdata (lh_rdata)
  );

  tbp_ram #(.WIDTH($bits(ctr_t)), .DEPTH(2 ** LOCAL_HIST_BITS)) u_lctr (
    .clk   (clk),
    .we    (lc_we),
    .waddr (lc_waddr),
    .wdata (lc_wdata),
    .raddr (lh_rdata),
    .rdata (lc_rdata)
  );

  tbp_ram #(.WIDTH($bits(gword_t)), .DEPTH(2 ** GLOBAL_HIST_BITS)) u_gmem (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (ghist),
    .rdata (g_rdata)
  );

  // A new branch needs the previous one's history written back and a buffer
  // slot for every result still on its way.
  assign occupancy    = {1'b0, cnt} + {2'b00, v2};
  assign branch.ready = !clearing && !v1 && (occupancy < 3'd2);

  // In the v1 stage the local history is known, so the new history is formed.
  assign lh_wide = {lh_rdata, s1_taken};
  assign gh_wide = {ghist, s1_taken};

  // In the v2 stage all counters are known.
  assign gp     = g_rdata.gctr[1];
  assign lp     = lc_rdata[1];
  assign use_g  = g_rdata.chooser[1];
  assign gc_new = sat_move(g_rdata.gctr, s2_taken);
  assign lc_new = sat_move(lc_rdata, s2_taken);
  assign cc_new = (gp != lp) ? sat_move(g_rdata.chooser, gp == s2_taken) : g_rdata.chooser;
  assign res.predicted_taken = use_g ? gp : lp;
  assign res.used_global     = use_g;

  always_comb begin
    lh_we    = clearing || v1;
    lh_waddr = clearing ? clr_idx[PC_INDEX_BITS-1:0] : s1_pidx;
    lh_wdata = clearing ? '0 : lh_wide[LOCAL_HIST_BITS-1:0];
    lc_we    = clearing || v2;
    lc_waddr = clearing ? clr_idx[LOCAL_HIST_BITS-1:0] : s2_lidx;
    lc_wdata = clearing ? CTR_WEAK_NT : lc_new;
    g_we     = clearing || v2;
    g_waddr  = clearing ? clr_idx[GLOBAL_HIST_BITS-1:0] : s2_gidx;
    if (clearing) begin
      g_wdata.chooser = CTR_WEAK_GLOBAL;
      g_wdata.gctr    = CTR_WEAK_NT;
    end else begin
      g_wdata.chooser = cc_new;
      g_wdata.gctr    = gc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      ghist    <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + CLR_BITS'(1);
        if (&clr_idx) begin
          clearing <= 1'b0;
        end
      end
      v1 <= branch.valid && branch.ready;
      v2 <= v1;
      if (v1) begin
        ghist <= gh_wide[GLOBAL_HIST_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (branch.valid && branch.ready) begin
      s1_pidx  <= branch.pc[PC_INDEX_BITS-1:0];
      s1_taken <= branch.taken;
    end
    if (v1) begin
      s2_lidx  <= lh_rdata;
      s2_gidx  <= ghist;
      s2_taken <= s1_taken;
    end
  end

  // Two-entry output buffer, head in buf0.
  assign push = v2;
  assign pop  = prediction.valid && prediction.ready;

  always_comb begin
    buf0_next = buf0;
    buf1_next = buf1;
    cnt_next  = cnt;
    if (pop) begin
      buf0_next = buf1;
      cnt_next  = cnt - 2'd1;
    end
    if (push) begin
      if (cnt_next == 2'd0) begin
        buf0_next = res;
      end else begin
        buf1_next = res;
      end
      cnt_next = cnt_next + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
    buf0 <= buf0_next;
    buf1 <= buf1_next;
  end

  assign prediction.valid           = (cnt != 2'd0);
  assign prediction.predicted_taken = buf0.predicted_taken;
  assign prediction.used_global     = buf0.used_global;

endmodule

>>> design/tbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/tournament_branch_predictor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_checker
// Watches the branch and prediction channels of the tournament predictor.
// It keeps its own copy of the global, chooser and local tables. From each
// branch transfer it works out the prediction the block should give, then
// trains that copy with the outcome. Each prediction transfer is compared
// field by field with the oldest prediction still pending.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_checker #(
  parameter int GLOBAL_HIST_BITS = 9,
  parameter int LOCAL_HIST_BITS  = 10,
  parameter int PC_INDEX_BITS    = 10
) (
  input  logic        clk,
  input  logic        rst,
  tbp_in_if           branch,
  tbp_out_if          prediction,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  import tbp_pkg::*;

  localparam int GHIST_DEPTH = 1 << GLOBAL_HIST_BITS;
  localparam int L_ENTRIES   = 1 << LOCAL_HIST_BITS;
  localparam int P_ENTRIES   = 1 << PC_INDEX_BITS;

  logic [GLOBAL_HIST_BITS-1:0] path_history;
  ctr_t                        global_ctrs  [GHIST_DEPTH];
  ctr_t                        chooser_ctrs [GHIST_DEPTH];
  logic [LOCAL_HIST_BITS-1:0]  branch_histories [P_ENTRIES];
  ctr_t                        local_ctrs   [L_ENTRIES];
  result_t                     pending_predictions [$];

  function automatic ctr_t train_ctr(input ctr_t c, input logic up);
    if (up && c != CTR_MAX) begin
      return c + 2'd1;
    end
    if (!up && c != CTR_ZERO) begin
      return c - 2'd1;
    end
    return c;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: prediction mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic predict_and_train(input logic [31:0] pc, input logic taken);
    logic [PC_INDEX_BITS-1:0]    pidx;
    logic [GLOBAL_HIST_BITS-1:0] gidx;
    logic [LOCAL_HIST_BITS-1:0]  lidx;
    logic                        global_says;
    logic                        local_says;
    logic                        pick_global;
    result_t                     due;
    pidx        = pc[PC_INDEX_BITS-1:0];
    gidx        = path_history;
    lidx        = branch_histories[pidx];
    // A 2-bit counter leans towards taken (or towards global) when its top bit is set.
    global_says = global_ctrs[gidx][1];
    local_says  = local_ctrs[lidx][1];
    pick_global = chooser_ctrs[gidx][1];
    due.predicted_taken = pick_global ? global_says : local_says;
    due.used_global     = pick_global;
    pending_predictions.push_back(due);

    local_ctrs[lidx]  = train_ctr(local_ctrs[lidx], taken);
    global_ctrs[gidx] = train_ctr(global_ctrs[gidx], taken);
    // The chooser only learns when the two components disagree.
    if (global_says != local_says) begin
      chooser_ctrs[gidx] = train_ctr(chooser_ctrs[gidx], global_says == taken);
    end
    branch_histories[pidx] = LOCAL_HIST_BITS'({lidx, taken});
    path_history           = GLOBAL_HIST_BITS'({gidx, taken});
  endtask

  task automatic compare_prediction(input logic got_taken, input logic got_global);
    result_t want;
    if (pending_predictions.size() == 0) begin
      flag_mismatch($sformatf("unexpected transfer, predicted_taken=%0b used_global=%0b",
                              got_taken, got_global));
    end else begin
      want = pending_predictions.pop_front();
      if (got_taken !== want.predicted_taken) begin
        flag_mismatch($sformatf("predicted_taken=%0b, expected %0b",
                                got_taken, want.predicted_taken));
      end
      if (got_global !== want.used_global) begin
        flag_mismatch($sformatf("used_global=%0b, expected %0b",
                                got_global, want.used_global));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mismatches   = 0;
      path_history = '0;
      for (int i = 0; i < GHIST_DEPTH; i++) begin
        global_ctrs[i]  = CTR_WEAK_NT;
        chooser_ctrs[i] = CTR_WEAK_GLOBAL;
      end
      for (int i = 0; i < P_ENTRIES; i++) begin
        branch_histories[i] = '0;
      end
      for (int i = 0; i < L_ENTRIES; i++) begin
        local_ctrs[i] = CTR_WEAK_NT;
      end
      pending_predictions.delete();
    end else begin
      // A result always belongs to an earlier branch, so it is checked first.
      if (prediction.valid && prediction.ready) begin
        compare_prediction(prediction.predicted_taken, prediction.used_global);
      end
      if (branch.valid && branch.ready) begin
        predict_and_train(branch.pc, branch.taken);
      end
    end
    outstanding <= pending_predictions.size();
  end

endmodule

>>> tb/tournament_branch_predictor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_unit_tb
// Drives resolved branches into the tournament predictor and stalls its
// result channel. A short directed run saturates the counters and fills the
// histories, then random loops, correlated pairs and noise follow under three
// idling mixes. A separate checker predicts and compares every transfer.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_unit_tb;

  // The clearing pass after reset alone runs without a transfer.
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 10;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;
  int unsigned branches_sent = 0;
  int          src_idle_pct;
  int          sink_idle_pct;
  logic [31:0] hot_pcs [16];

  tbp_in_if  branch ();
  tbp_out_if prediction ();

  tournament_branch_predictor_unit dut (
    .clk        (clk),
    .rst        (rst),
    .branch     (branch),
    .prediction (prediction)
  );

  tournament_branch_predictor_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .branch      (branch),
    .prediction  (prediction),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    prediction.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (branch.valid && branch.ready) || (prediction.valid && prediction.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[tournament_branch_predictor_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  // Each cycle before the offer is an idle one with the sender's idle odds.
  task automatic send_branch(input logic [31:0] pc, input logic taken);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      branch.valid <= 1'b0;
      @(negedge clk);
    end
    branch.valid <= 1'b1;
    branch.pc    <= pc;
    branch.taken <= taken;
    do @(posedge clk); while (!branch.ready);
    @(negedge clk);
    branches_sent++;
  endtask

  // A counted loop: taken on every pass but the last.
  task automatic run_loop(input logic [31:0] pc, input int trips, input int reps);
    for (int r = 0; r < reps; r++) begin
      for (int i = 0; i < trips; i++) begin
        send_branch(pc, i != trips - 1);
      end
    end
  endtask

  task automatic run_random(input int unsigned target);
    int          kind;
    logic [31:0] pc_a;
    logic [31:0] pc_b;
    logic        outcome;
    while (branches_sent < target) begin
      kind    = $urandom_range(0, 9);
      pc_a    = hot_pcs[$urandom_range(0, 15)];
      pc_b    = hot_pcs[$urandom_range(0, 15)];
      outcome = $urandom_range(0, 1);
      if (kind < 5) begin
        run_loop(pc_a, $urandom_range(2, 12), $urandom_range(1, 3));
      end else if (kind < 8) begin
        // Two branches whose outcomes follow each other, which only the
        // global history can capture.
        send_branch(pc_a, outcome);
        send_branch(pc_b, outcome);
      end else begin
        send_branch($urandom, $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    branch.valid     = 1'b0;
    branch.pc        = '0;
    branch.taken     = 1'b0;
    prediction.ready = 1'b0;
    src_idle_pct     = 37;
    sink_idle_pct    = 50;
    foreach (hot_pcs[i]) hot_pcs[i] = $urandom;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drive every counter on the path to its floor, then to its ceiling with
    // the global and local histories all ones.
    run_loop(32'h0000_0000, 1, 6);
    repeat (12) send_branch(32'hFFFF_FFFF, 1'b1);
    // Upper address bits must not change the table entry.
    send_branch(32'hFFFF_FC00, 1'b1);
    send_branch(32'h0000_03FF, 1'b0);
    send_branch(32'h5555_5555, 1'b1);
    send_branch(32'hAAAA_AAAA, 1'b0);
    send_branch(32'h5555_5555, 1'b0);
    send_branch(32'hAAAA_AAAA, 1'b1);

    run_random(307);
    src_idle_pct  = 50;
    sink_idle_pct = 37;
    run_random(590);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(874);
    branch.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("[tournament_branch_predictor_unit] OK");
    end else begin
      $display("[tournament_branch_predictor_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/tbp_pkg.sv
design/tbp_in_if.sv
design/tbp_out_if.sv
design/tbp_ram.sv
design/tournament_branch_predictor_unit.sv
tb/tournament_branch_predictor_checker.sv
tb/tournament_branch_predictor_unit_tb.sv
